### design/hypocycloid_point_generator_unit_assert.svh
// assertion macros for the hypocycloid point generator
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef HYPOCYCLOID_POINT_GENERATOR_UNIT_ASSERT_SVH
`define HYPOCYCLOID_POINT_GENERATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpg check failed");
// next-cycle implication
`define HPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpg check failed");
`else
`define HPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/hpg_pkg.sv
// shared types, constants and sine table for the hypocycloid point generator
// no dependencies
package hpg_pkg;

    localparam int PHASE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 13;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int ORIGIN_W = 12;
    localparam int RADIUS_W = 11;
    localparam int STEP_W   = 16;
    localparam int TRIG_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_OUTER_RADIUS = 3'd2,
        REG_INNER_RADIUS = 3'd3,
        REG_THETA_STEP   = 3'd4,
        REG_ROLL_STEP    = 3'd5
    } cfg_reg_t;

    localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST     = 12'd0;
    localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST     = 12'd0;
    localparam logic [RADIUS_W-1:0] OUTER_RADIUS_RST = 11'd64;
    localparam logic [RADIUS_W-1:0] INNER_RADIUS_RST = 11'd21;
    localparam logic [STEP_W-1:0]   THETA_STEP_RST   = 16'd1043;
    localparam logic [STEP_W-1:0]   ROLL_STEP_RST    = 16'd2136;

    typedef logic signed [TRIG_W-1:0] trig_t;

    // first quadrant of the sine in q1.15, 64 steps plus the end point
    function automatic logic [TRIG_W-1:0] quarter_sine(input logic [6:0] j);
        logic [TRIG_W-1:0] v;
        case (j)
            7'd0:  v = 16'd0;     7'd1:  v = 16'd804;   7'd2:  v = 16'd1608;
            7'd3:  v = 16'd2411;  7'd4:  v = 16'd3212;  7'd5:  v = 16'd4011;
            7'd6:  v = 16'd4808;  7'd7:  v = 16'd5602;  7'd8:  v = 16'd6393;
            7'd9:  v = 16'd7179;  7'd10: v = 16'd7962;  7'd11: v = 16'd8739;
            7'd12: v = 16'd9512;  7'd13: v = 16'd10278; 7'd14: v = 16'd11039;
            7'd15: v = 16'd11793; 7'd16: v = 16'd12539; 7'd17: v = 16'd13279;
            7'd18: v = 16'd14010; 7'd19: v = 16'd14732; 7'd20: v = 16'd15446;
            7'd21: v = 16'd16151; 7'd22: v = 16'd16846; 7'd23: v = 16'd17530;
            7'd24: v = 16'd18204; 7'd25: v = 16'd18868; 7'd26: v = 16'd19519;
            7'd27: v = 16'd20159; 7'd28: v = 16'd20787; 7'd29: v = 16'd21403;
            7'd30: v = 16'd22005; 7'd31: v = 16'd22594; 7'd32: v = 16'd23170;
            7'd33: v = 16'd23731; 7'd34: v = 16'd24279; 7'd35: v = 16'd24811;
            7'd36: v = 16'd25329; 7'd37: v = 16'd25832; 7'd38: v = 16'd26319;
            7'd39: v = 16'd26790; 7'd40: v = 16'd27245; 7'd41: v = 16'd27683;
            7'd42: v = 16'd28105; 7'd43: v = 16'd28510; 7'd44: v = 16'd28898;
            7'd45: v = 16'd29268; 7'd46: v = 16'd29621; 7'd47: v = 16'd29956;
            7'd48: v = 16'd30273; 7'd49: v = 16'd30571; 7'd50: v = 16'd30852;
            7'd51: v = 16'd31113; 7'd52: v = 16'd31356; 7'd53: v = 16'd31580;
            7'd54: v = 16'd31785; 7'd55: v = 16'd31971; 7'd56: v = 16'd32137;
            7'd57: v = 16'd32285; 7'd58: v = 16'd32412; 7'd59: v = 16'd32521;
            7'd60: v = 16'd32609; 7'd61: v = 16'd32678; 7'd62: v = 16'd32728;
            7'd63: v = 16'd32757; 7'd64: v = 16'd32767;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // full-turn sine at 256 steps per turn, folded from the quarter wave
    function automatic trig_t table_sine(input logic [7:0] idx);
        logic [6:0]        j;
        logic [6:0]        jm;
        logic [TRIG_W-1:0] q;
        trig_t             s;
        j  = {1'b0, idx[5:0]};
        jm = 7'd64 - j;
        case (idx[7:6])
            2'd0:    begin q = quarter_sine(j);  s = $signed(q);  end
            2'd1:    begin q = quarter_sine(jm); s = $signed(q);  end
            2'd2:    begin q = quarter_sine(j);  s = -$signed(q); end
            default: begin q = quarter_sine(jm); s = -$signed(q); end
        endcase
        return s;
    endfunction

endpackage

### design/hpg_if.sv
// valid/ready channel interfaces for the hypocycloid point generator
// depends on hpg_pkg for the default coordinate width
interface hpg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface hpg_out_if #(
    parameter int COORD_BITS = hpg_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink (input valid, input point_x, input point_y, output ready);
endinterface

### design/hpg_phase_acc.sv
// phase accumulator with restart; presents the phase aligned to 16 bits
// depends on hpg_pkg
module hpg_phase_acc #(
    parameter int PHASE_BITS = hpg_pkg::PHASE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        accept,
    input  logic                        restart,
    input  logic [hpg_pkg::STEP_W-1:0]  step,
    output logic [15:0]                 p16_reg
);
    import hpg_pkg::*;

    logic [PHASE_BITS-1:0]        phase_reg;
    logic [PHASE_BITS-1:0]        phase_next;
    logic [PHASE_BITS-1:0]        cur;
    logic [PHASE_BITS-1:0]        step_al;
    logic [STEP_W+PHASE_BITS-1:0] step_wide;
    logic [PHASE_BITS+15:0]       ph_wide;
    logic [15:0]                  p16_next;

    // step << P >> 16 and phase << 16 >> P cover both alignment directions
    always_comb
    begin
        cur        = restart ? '0 : phase_reg;
        step_wide  = {step, {PHASE_BITS{1'b0}}} >> STEP_W;
        step_al    = step_wide[PHASE_BITS-1:0];
        phase_next = cur + step_al;
        ph_wide    = {cur, 16'd0} >> PHASE_BITS;
        p16_next   = ph_wide[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p16_reg <= p16_next;
        end
    end

endmodule

### design/hpg_sincos.sv
// two-stage interpolated sine and cosine of a 16-bit phase
// depends on hpg_pkg for the table and trig_t
module hpg_sincos (
    input  logic           clk,
    input  logic           adv,
    input  logic [15:0]    p16,
    output hpg_pkg::trig_t sin_reg,
    output hpg_pkg::trig_t cos_reg
);
    import hpg_pkg::*;

    logic [15:0]        pc;
    trig_t              s0_sin;
    trig_t              s0_cos;
    logic signed [16:0] dl_sin;
    logic signed [16:0] dl_cos;

    trig_t              s0_sin_reg;
    trig_t              s0_cos_reg;
    logic signed [16:0] dl_sin_reg;
    logic signed [16:0] dl_cos_reg;
    logic [7:0]         f_sin_reg;
    logic [7:0]         f_cos_reg;

    logic signed [25:0] pr_sin;
    logic signed [25:0] pr_cos;
    logic signed [25:0] rs_sin;
    logic signed [25:0] rs_cos;
    trig_t              sin_next;
    trig_t              cos_next;

    // table stage: end points of the segment and their difference
    always_comb
    begin
        pc     = p16 + 16'd16384;
        s0_sin = table_sine(p16[15:8]);
        s0_cos = table_sine(pc[15:8]);
        dl_sin = 17'(table_sine(p16[15:8] + 8'd1)) - 17'(s0_sin);
        dl_cos = 17'(table_sine(pc[15:8] + 8'd1)) - 17'(s0_cos);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_sin_reg <= s0_sin;
            s0_cos_reg <= s0_cos;
            dl_sin_reg <= dl_sin;
            dl_cos_reg <= dl_cos;
            f_sin_reg  <= p16[7:0];
            f_cos_reg  <= pc[7:0];
        end
    end

    // interpolation, rounded half up and floored
    always_comb
    begin
        pr_sin   = 26'(dl_sin_reg) * 26'($signed({1'b0, f_sin_reg}));
        pr_cos   = 26'(dl_cos_reg) * 26'($signed({1'b0, f_cos_reg}));
        rs_sin   = (pr_sin + 26'sd128) >>> 8;
        rs_cos   = (pr_cos + 26'sd128) >>> 8;
        sin_next = s0_sin_reg + rs_sin[TRIG_W-1:0];
        cos_next = s0_cos_reg + rs_cos[TRIG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

endmodule

### design/hpg_coord.sv
// one coordinate: two radius products, then sum, round and saturate
// depends on hpg_pkg
module hpg_coord #(
    parameter int COORD_BITS = hpg_pkg::COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   adv,
    input  logic [12:0]            base,
    input  logic signed [11:0]     coef_a,
    input  hpg_pkg::trig_t         trig_a,
    input  logic signed [11:0]     coef_b,
    input  hpg_pkg::trig_t         trig_b,
    input  logic                   sub_b,
    output logic [COORD_BITS-1:0]  coord_reg
);
    import hpg_pkg::*;

    localparam logic signed [31:0] COORD_MAX = 32'((64'd1 << COORD_BITS) - 64'd1);

    logic [12:0]        base_reg;
    logic signed [27:0] pa_reg;
    logic signed [27:0] pb_reg;
    logic               sub_reg;

    logic signed [31:0]    acc;
    logic signed [31:0]    q;
    logic [COORD_BITS-1:0] coord_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            base_reg <= base;
            pa_reg   <= 28'(coef_a) * 28'(trig_a);
            pb_reg   <= 28'(coef_b) * 28'(trig_b);
            sub_reg  <= sub_b;
        end
    end

    // q.15 sum, floor((sum + half) / 2^15), clamp to the coordinate range
    always_comb
    begin
        acc = $signed({4'd0, base_reg, 15'd0}) + 32'(pa_reg) + 32'sd16384;
        if (sub_reg)
        begin
            acc = acc - 32'(pb_reg);
        end
        else
        begin
            acc = acc + 32'(pb_reg);
        end
        q = acc >>> 15;
        if (q < 0)
        begin
            coord_next = '0;
        end
        else if (q > COORD_MAX)
        begin
            coord_next = COORD_MAX[COORD_BITS-1:0];
        end
        else
        begin
            coord_next = q[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            coord_reg <= coord_next;
        end
    end

endmodule

### design/hypocycloid_point_generator_unit.sv
// Hypocycloid point generator. Each accepted beat on tick yields one beat on
// point, in order, at one point per clock unless point holds off. A point
// passes these stages: phase register, sine table, interpolation multiply,
// radius multiply, then sum/round/saturate into the output register. All
// stages move together; when point is held off with a result waiting, the
// whole pipe and tick.ready hold. restart zeroes both phases before the
// point is formed. Write configuration only while the pipe is empty.
module hypocycloid_point_generator_unit #(
    parameter int PHASE_BITS = hpg_pkg::PHASE_BITS_DEF,
    parameter int COORD_BITS = hpg_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hpg_pkg::CFG_DATA_W-1:0] cfg_data,
    hpg_in_if.sink                         tick,
    hpg_out_if.source                      point
);
    import hpg_pkg::*;
`include "hypocycloid_point_generator_unit_assert.svh"

    logic [ORIGIN_W-1:0] origin_x_reg;
    logic [ORIGIN_W-1:0] origin_y_reg;
    logic [RADIUS_W-1:0] outer_radius_reg;
    logic [RADIUS_W-1:0] inner_radius_reg;
    logic [STEP_W-1:0]   theta_step_reg;
    logic [STEP_W-1:0]   roll_step_reg;

    logic        adv;
    logic        accept;
    logic [3:0]  v_reg;
    logic        out_valid_reg;

    logic [15:0] main_p16;
    logic [15:0] roll_p16;
    trig_t       sin_t;
    trig_t       cos_t;
    trig_t       sin_u;
    trig_t       cos_u;

    logic signed [11:0] diff;
    logic signed [11:0] small_r;
    logic [12:0]        base_x;
    logic [12:0]        base_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= ORIGIN_X_RST;
            origin_y_reg     <= ORIGIN_Y_RST;
            outer_radius_reg <= OUTER_RADIUS_RST;
            inner_radius_reg <= INNER_RADIUS_RST;
            theta_step_reg   <= THETA_STEP_RST;
            roll_step_reg    <= ROLL_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:     origin_x_reg     <= cfg_data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_data[ORIGIN_W-1:0];
                REG_OUTER_RADIUS: outer_radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_INNER_RADIUS: inner_radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_THETA_STEP:   theta_step_reg   <= cfg_data[STEP_W-1:0];
                REG_ROLL_STEP:    roll_step_reg    <= cfg_data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    assign adv        = !out_valid_reg || point.ready;
    assign accept     = tick.valid && adv;
    assign tick.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[2:0], accept};
            out_valid_reg <= v_reg[3];
        end
    end

    hpg_phase_acc #(
        .PHASE_BITS (PHASE_BITS)
    ) u_main_phase (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .accept  (accept),
        .restart (tick.restart),
        .step    (theta_step_reg),
        .p16_reg (main_p16)
    );

    hpg_phase_acc #(
        .PHASE_BITS (PHASE_BITS)
    ) u_roll_phase (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .accept  (accept),
        .restart (tick.restart),
        .step    (roll_step_reg),
        .p16_reg (roll_p16)
    );

    hpg_sincos u_trig_main (
        .clk     (clk),
        .adv     (adv),
        .p16     (main_p16),
        .sin_reg (sin_t),
        .cos_reg (cos_t)
    );

    hpg_sincos u_trig_roll (
        .clk     (clk),
        .adv     (adv),
        .p16     (roll_p16),
        .sin_reg (sin_u),
        .cos_reg (cos_u)
    );

    // R - r may go negative when the inner circle is the larger one
    assign diff    = $signed({1'b0, outer_radius_reg}) - $signed({1'b0, inner_radius_reg});
    assign small_r = $signed({1'b0, inner_radius_reg});
    assign base_x  = {1'b0, origin_x_reg} + {2'b00, outer_radius_reg};
    assign base_y  = {1'b0, origin_y_reg} + {2'b00, outer_radius_reg};

    hpg_coord #(
        .COORD_BITS (COORD_BITS)
    ) u_coord_x (
        .clk       (clk),
        .adv       (adv),
        .base      (base_x),
        .coef_a    (diff),
        .trig_a    (cos_t),
        .coef_b    (small_r),
        .trig_b    (cos_u),
        .sub_b     (1'b0),
        .coord_reg (point.point_x)
    );

    hpg_coord #(
        .COORD_BITS (COORD_BITS)
    ) u_coord_y (
        .clk       (clk),
        .adv       (adv),
        .base      (base_y),
        .coef_a    (diff),
        .trig_a    (sin_t),
        .coef_b    (small_r),
        .trig_b    (sin_u),
        .sub_b     (1'b1),
        .coord_reg (point.point_y)
    );

    assign point.valid = out_valid_reg;

    `HPG_ASSERT_NXT(a_restart_zero, clk, rst_n, accept && tick.restart, main_p16 == 16'd0 && roll_p16 == 16'd0)
    `HPG_ASSERT_NXT(a_accept_enters, clk, rst_n, accept, v_reg[0])
    `HPG_ASSERT_NXT(a_stall_holds, clk, rst_n, !adv, $stable(v_reg) && out_valid_reg)
    `HPG_ASSERT_IMP(a_out_from_pipe, clk, rst_n, $rose(out_valid_reg), $past(v_reg[3]))

endmodule
